FILE: sv/hns_pkg.sv
`default_nettype none
package hns_pkg;

  localparam int GainW   = 16;
  localparam int SideW   = 11;
  localparam int MagW    = 24;
  localparam int AccW    = 50;
  localparam int RootW   = 26;
  localparam int DivW    = 40;
  localparam int QuoW    = 15;
  localparam int SqrtN   = 25;
  localparam int CntW    = 5;

  localparam logic [SideW-1:0] SIDE_RESET = 11'd256;
  localparam logic [GainW-1:0] GAIN_RESET = 16'd512;
  localparam logic [0:0]       REG_SIDE   = 1'b0;
  localparam logic [0:0]       REG_GAIN   = 1'b1;

  typedef enum logic [1:0] {
    SEL_X = 2'd0,
    SEL_Y = 2'd1,
    SEL_Z = 2'd2
  } comp_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD1,
    ST_RD2,
    ST_MULX,
    ST_MULZ,
    ST_MULH,
    ST_SQX,
    ST_SQZ,
    ST_SQRT,
    ST_DIVI,
    ST_DIVS,
    ST_DIVW,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic            load_in;
    logic            clear_pos;
    logic            rd0;
    logic            rd1;
    logic            rd2;
    logic            mulx;
    logic            mulz;
    logic            mulh;
    logic            sqx;
    logic            sqz;
    logic            sqrt_step;
    logic [CntW-1:0] k;
    logic            div_init;
    logic            div_step;
    logic            div_store;
    comp_sel_t       sel;
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic drop;
    logic clr;
    logic emit;
    logic out_full;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/hns_ctrl.sv
`default_nettype none
module hns_ctrl import hns_pkg::*; (
  input  wire     clk,
  input  wire     rst,
  input  wire     in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t          state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  comp_sel_t       sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      sel   <= SEL_X;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    sel_next   = sel;
    cmd        = '0;
    cmd.k      = cnt;
    cmd.sel    = sel;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.drop) begin
          cmd.clear_pos = st.clr;
          state_next    = ST_IDLE;
        end else begin
          cmd.rd0    = 1'b1;
          state_next = ST_RD1;
        end
      end
      ST_RD1: begin
        cmd.rd1    = 1'b1;
        state_next = ST_RD2;
      end
      ST_RD2: begin
        cmd.rd2    = 1'b1;
        state_next = st.emit ? ST_MULX : ST_IDLE;
      end
      ST_MULX: begin
        cmd.mulx   = 1'b1;
        state_next = ST_MULZ;
      end
      ST_MULZ: begin
        cmd.mulz   = 1'b1;
        state_next = ST_MULH;
      end
      ST_MULH: begin
        cmd.mulh   = 1'b1;
        state_next = ST_SQX;
      end
      ST_SQX: begin
        cmd.sqx    = 1'b1;
        state_next = ST_SQZ;
      end
      ST_SQZ: begin
        cmd.sqz    = 1'b1;
        cnt_next   = CntW'(SqrtN - 1);
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == '0) begin
          sel_next   = SEL_X;
          state_next = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next     = CntW'(QuoW - 1);
        state_next   = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == '0) state_next = ST_DIVW;
      end
      ST_DIVW: begin
        cmd.div_store = 1'b1;
        case (sel)
          SEL_X:   begin sel_next = SEL_Y; state_next = ST_DIVI; end
          SEL_Y:   begin sel_next = SEL_Z; state_next = ST_DIVI; end
          default: state_next = ST_LOAD;
        endcase
      end
      ST_LOAD: begin
        if (!st.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/hns_dp.sv
`default_nettype none
module hns_dp import hns_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              cfg_we,
  input  wire  [0:0]       cfg_index,
  input  wire  [15:0]      cfg_data,
  input  wire              in_mode,
  input  wire  [7:0]       in_pixel,
  input  cmd_t             cmd,
  output status_t          st,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [MagW-1:0]  out_height,
  output logic [15:0]      out_nx,
  output logic [14:0]      out_ny,
  output logic [15:0]      out_nz,
  output logic             out_last
);

  localparam int AW = $clog2(MAX_SIDE);

  logic [7:0] upper_mem [MAX_SIDE];
  logic [7:0] mid_mem   [MAX_SIDE];

  logic [SideW-1:0] side, col, row, s_eff;
  logic [GainW-1:0] gain;
  logic             flush, lastf;
  logic [7:0]       pix, left, lft, ctr, up, rgt, upper_q, mid_q, down;
  logic [AW-1:0]    addr_c, addr_n, mid_raddr;
  logic             cond1;

  logic signed [8:0]  mop;
  logic signed [25:0] mprod;
  logic [MagW-1:0]    mmag, ax, az, height, sq_op;
  logic               x_neg, z_neg;
  logic [47:0]        sq, sqx_r;
  logic [AccW-1:0]    srem, sres, sbit, st_sum;
  logic [RootW-1:0]   root;
  logic [DivW-1:0]    drem, dd, dnum;
  logic [MagW-1:0]    dmag;
  logic [QuoW-1:0]    q;
  logic [15:0]        nx, nz;
  logic [14:0]        ny;

  assign down   = flush ? 8'd0 : pix;
  assign addr_c = AW'(col);
  assign addr_n = AW'(col + 1'b1);
  assign mid_raddr = cmd.rd1 ? addr_n : addr_c;

  always_comb begin
    s_eff = side;
    if (side < 11'd2) s_eff = 11'd2;
    else if ({2'b0, side} > 13'(MAX_SIDE)) s_eff = SideW'(MAX_SIDE);
  end

  assign cond1       = flush ? (row != s_eff) : (row >= s_eff);
  assign st.drop     = cond1 || (col >= s_eff);
  assign st.clr      = !cond1 && (col >= s_eff);
  assign st.emit     = row != '0;
  assign st.out_full = out_valid;

  always_ff @(posedge clk) begin
    if (cmd.rd0) upper_q <= upper_mem[addr_c];
    if (cmd.rd2) upper_mem[addr_c] <= ctr;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd0 || cmd.rd1) mid_q <= mid_mem[mid_raddr];
    if (cmd.rd2) mid_mem[addr_c] <= down;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SIDE_RESET;
      gain <= GAIN_RESET;
      col  <= '0;
      row  <= '0;
      left <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIDE: begin
          side <= cfg_data[SideW-1:0];
          col  <= '0;
          row  <= '0;
          left <= '0;
        end
        REG_GAIN: gain <= cfg_data;
        default:  gain <= gain;
      endcase
    end else begin
      if (cmd.clear_pos) begin
        col  <= '0;
        row  <= '0;
        left <= '0;
      end
      if (cmd.rd1) left <= mid_q;
      if (cmd.rd2) begin
        if (flush && (col == s_eff - 1'b1)) begin
          col  <= '0;
          row  <= '0;
          left <= '0;
        end else if (col + 1'b1 >= s_eff) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      flush <= in_mode;
      pix   <= in_pixel;
    end
    if (cmd.rd1) begin
      lft <= (col != '0) ? left : 8'd0;
      ctr <= mid_q;
      up  <= (row >= 11'd2) ? upper_q : 8'd0;
    end
    if (cmd.rd2) begin
      rgt   <= (col + 1'b1 < s_eff) ? mid_q : 8'd0;
      lastf <= flush && (col == s_eff - 1'b1);
    end
  end

  always_comb begin
    if (cmd.mulx)      mop = $signed({1'b0, lft}) - $signed({1'b0, rgt});
    else if (cmd.mulz) mop = $signed({1'b0, up}) - $signed({1'b0, down});
    else               mop = $signed({1'b0, ctr});
    mprod = mop * $signed({1'b0, gain});
    mmag  = mprod[25] ? MagW'(-mprod) : MagW'(mprod);
  end

  assign sq_op = cmd.sqx ? ax : az;
  assign sq    = sq_op * sq_op;

  assign sbit   = AccW'(1) << {cmd.k, 1'b0};
  assign st_sum = sres + sbit;
  assign root   = sres[RootW-1:0];

  always_comb begin
    case (cmd.sel)
      SEL_X:   dmag = ax;
      SEL_Y:   dmag = MagW'(512);
      default: dmag = az;
    endcase
    dnum = {2'b0, dmag, 14'b0} + DivW'(root >> 1);
  end

  always_ff @(posedge clk) begin
    if (cmd.mulx) begin
      ax    <= mmag;
      x_neg <= mprod[25];
    end
    if (cmd.mulz) begin
      az    <= mmag;
      z_neg <= mprod[25];
    end
    if (cmd.mulh) height <= MagW'(mprod);
    if (cmd.sqx) sqx_r <= sq;
    if (cmd.sqz) begin
      srem <= {2'b0, sqx_r} + {2'b0, sq} + AccW'(262144);
      sres <= '0;
    end
    if (cmd.sqrt_step) begin
      if (srem >= st_sum) begin
        srem <= srem - st_sum;
        sres <= (sres >> 1) + sbit;
      end else begin
        sres <= sres >> 1;
      end
    end
    if (cmd.div_init) begin
      drem <= dnum;
      dd   <= {root, 14'b0};
      q    <= '0;
    end
    if (cmd.div_step) begin
      if (drem >= dd) begin
        drem <= drem - dd;
        q    <= {q[QuoW-2:0], 1'b1};
      end else begin
        q <= {q[QuoW-2:0], 1'b0};
      end
      dd <= dd >> 1;
    end
    if (cmd.div_store) begin
      case (cmd.sel)
        SEL_X:   nx <= x_neg ? -{1'b0, q} : {1'b0, q};
        SEL_Y:   ny <= q;
        default: nz <= z_neg ? -{1'b0, q} : {1'b0, q};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_height <= height;
      out_nx     <= nx;
      out_ny     <= ny;
      out_nz     <= nz;
      out_last   <= lastf;
    end
  end

endmodule
`default_nettype wire

FILE: sv/heightmap_normal_stream_core.sv
// channel  | direction | tdata (low bit up)                         | tuser / tlast
// s_axis   | in        | pixel[7:0]                                 | tuser: mode
// m_axis   | out       | height, normal_x, normal_y, normal_z, pad  | tlast: last_of_frame
// cfg      | in        | index 0 side_length, index 1 height_gain   | -
//
// A word that yields a result runs, in order and before the next ready: acceptance,
// the position check, the row-store reads and window update, the gain products
// and squares, the square root, the three restoring divisions of the shared
// divider, then the load of the output register. A word that yields no result
// ends after the row-store reads, or after the position check when it is dropped.
// Synchronous reset clears position, output valid and the registers to their
// defaults; the row stores are not cleared. A stalled output holds in its
// register while the next word is taken in; the load waits until it drains.
`default_nettype none
module heightmap_normal_stream_core import hns_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [15:0] cfg_data,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // pixel[7:0]
  input  wire  [0:0]  s_axis_tuser,   // mode[0]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [71:0] m_axis_tdata,   // height[23:0] nx[39:24] ny[54:40] nz[70:55] zero[71]
  output logic        m_axis_tlast
);

  cmd_t        cmd;
  status_t     st;
  logic [23:0] height;
  logic [15:0] nx, nz;
  logic [14:0] ny;

  hns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  hns_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_mode    (s_axis_tuser[0]),
    .in_pixel   (s_axis_tdata),
    .cmd        (cmd),
    .st         (st),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_height (height),
    .out_nx     (nx),
    .out_ny     (ny),
    .out_nz     (nz),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, nz, ny, nx, height};

endmodule
`default_nettype wire

FILE: dv/tb_heightmap_normal_stream_core.sv
`default_nettype none
module tb_heightmap_normal_stream_core;
  import hns_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 120;
  localparam int ITEM_TARGET = 1100;

  typedef struct packed {
    logic [23:0] height;
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
    logic        last;
  } normal_word_t;

  class normal_scoreboard;
    logic [7:0] upper_row[1024];
    logic [7:0] middle_row[1024];
    logic [7:0] left_px;
    int unsigned col, row, side, gain;
    normal_word_t pending[$];
    int errors;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i] = 8'd0;
        middle_row[i] = 8'd0;
      end
      side = SIDE_RESET;
      gain = GAIN_RESET;
      col = 0;
      row = 0;
      left_px = 8'd0;
      errors = 0;
    endfunction

    function int unsigned eff_side();
      if (side < 2) return 2;
      if (side > 1024) return 1024;
      return side;
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == REG_SIDE) begin
        side = val & 16'h07FF;
        col = 0;
        row = 0;
        left_px = 8'd0;
      end else begin
        gain = val;
      end
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
        if (v >= res + bits) begin
          v = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
      return res;
    endfunction

    function logic [15:0] scale(longint v, longint sq);
      longint mag, n;
      mag = (v < 0) ? -v : v;
      n = (mag * 16384 + sq / 2) / sq;
      if (v < 0) n = -n;
      return n[15:0];
    endfunction

    function void note(logic mode, logic [7:0] px);
      int unsigned s;
      logic [7:0] down;
      longint l, r, up, cen, g, vx, vz, sq;
      logic [15:0] ny;
      normal_word_t w;
      bit last;
      s = eff_side();
      down = mode ? 8'd0 : px;
      if (mode ? (row != s) : (row >= s)) return;
      if (col >= s) begin
        col = 0;
        row = 0;
        left_px = 8'd0;
        return;
      end
      last = mode && (col == s - 1);
      if (row >= 1) begin
        l = (col > 0) ? left_px : 0;
        cen = middle_row[col];
        r = (col + 1 < s) ? middle_row[col + 1] : 0;
        up = (row >= 2) ? upper_row[col] : 0;
        g = gain;
        vx = l * g - r * g;
        vz = up * g - longint'(down) * g;
        sq = root(vx * vx + 262144 + vz * vz);
        w.height = 24'(cen * g);
        w.nx = scale(vx, sq);
        ny = scale(512, sq);
        w.ny = ny[14:0];
        w.nz = scale(vz, sq);
        w.last = last;
        pending = {pending, w};
      end
      left_px = middle_row[col];
      upper_row[col] = middle_row[col];
      middle_row[col] = down;
      if (last) begin
        col = 0;
        row = 0;
        left_px = 8'd0;
      end else begin
        col++;
        if (col >= s) begin
          col = 0;
          row++;
        end
      end
    endfunction

    function void check(logic [71:0] data, logic last);
      normal_word_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected word: data %h last %b", $time, data, last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[23:0] !== e.height) begin
        $display("%0t height: expected %0d actual %0d", $time, e.height, data[23:0]);
        errors++;
      end
      if (data[39:24] !== e.nx) begin
        $display("%0t normal_x: expected %0d actual %0d", $time,
                 $signed(e.nx), $signed(data[39:24]));
        errors++;
      end
      if (data[54:40] !== e.ny) begin
        $display("%0t normal_y: expected %0d actual %0d", $time, e.ny, data[54:40]);
        errors++;
      end
      if (data[70:55] !== e.nz) begin
        $display("%0t normal_z: expected %0d actual %0d", $time,
                 $signed(e.nz), $signed(data[70:55]));
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t last: expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_SIDE;
  logic [15:0] cfg_data = 16'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;
  logic [0:0]  s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;

  normal_scoreboard sb = new();
  int send_idle = 30;
  int recv_idle = 80;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int pixel_count = 0;

  heightmap_normal_stream_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata, m_axis_tlast);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served < hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_word(logic mode, logic [7:0] px);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= px;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note(mode, px);
  endtask

  task automatic wait_empty();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_frame(int s, int cut, bit noisy);
    for (int i = 0; i < s * s && i < cut; i++) begin
      if (pixel_count < 400) begin
        send_idle = 30;
        recv_idle = 80;
      end else if (pixel_count < 800) begin
        send_idle = 80;
        recv_idle = 30;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (noisy && $urandom_range(15) == 0) send_word(1'b1, pick_pixel());
      send_word(1'b0, pick_pixel());
      pixel_count++;
    end
    if (cut < s * s) return;
    if (noisy && $urandom_range(3) == 0) send_word(1'b0, pick_pixel());
    for (int i = 0; i < s; i++) send_word(1'b1, pick_pixel());
  endtask

  initial begin
    int s, cut, frame_no;
    logic [15:0] side_val, gain_val;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_GAIN, 16'hFFFF);
    write_reg(REG_SIDE, 16'd0);
    send_word(1'b1, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'h00);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, 8'hAA);
    send_word(1'b1, 8'h55);
    send_word(1'b1, 8'hFF);
    wait_empty();
    write_reg(REG_GAIN, 16'd0);
    write_reg(REG_SIDE, 16'd1);
    send_frame(2, 4, 1'b0);
    wait_empty();
    write_reg(REG_SIDE, 16'd3);
    for (int i = 0; i < 4; i++) send_word(1'b0, 8'hFF);
    wait_empty();
    write_reg(REG_GAIN, 16'd256);
    for (int i = 0; i < 5; i++) send_word(1'b0, 8'(i * 63));
    for (int i = 0; i < 3; i++) send_word(1'b1, 8'h00);

    frame_no = 0;
    while (pixel_count < ITEM_TARGET) begin
      wait_empty();
      if (frame_no == 3) side_val = 16'hFFFF;
      else if ($urandom_range(9) == 0) side_val = 16'($urandom_range(2));
      else side_val = 16'($urandom_range(2, 10));
      case ($urandom_range(7))
        0: gain_val = 16'd0;
        1: gain_val = 16'hFFFF;
        default: gain_val = 16'($urandom_range(65535));
      endcase
      write_reg(REG_GAIN, gain_val);
      write_reg(REG_SIDE, side_val);
      s = sb.eff_side();
      if (frame_no == 3) cut = s + 8;
      else if ($urandom_range(9) == 0) cut = $urandom_range(1, s * s - 1);
      else cut = s * s;
      if (frame_no == 1 || frame_no == 2) hold_requests++;
      send_frame(s, cut, $urandom_range(3) == 0);
      frame_no++;
    end

    wait_empty();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
sv/hns_pkg.sv
sv/hns_ctrl.sv
sv/hns_dp.sv
sv/heightmap_normal_stream_core.sv
dv/tb_heightmap_normal_stream_core.sv
